/* sv/rrd_pkg.sv */
// Shared types and constants for the receive-ring record deframer.
// No dependencies; imported by rrd_skid and rx_ring_record_deframer_unit.
package rrd_pkg;

	localparam int RING_BYTES_DEF = 8192;
	localparam int TDATA_W        = 96;

	localparam logic [11:0] MAX_LEN_RST    = 12'd1518;
	localparam logic [15:0] MIN_FRAME_LEN  = 16'd14;
	localparam logic [16:0] CRC_LEN        = 17'd4;
	localparam logic [16:0] PAD_ROUND      = 17'd3;
	localparam logic [15:0] PTR_REPORT_OFS = 16'd16;
	localparam logic [15:0] STATUS_OK_MASK = 16'h0001;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// header byte positions, little-endian status then length
	localparam logic [1:0] HDR_STATUS_LO = 2'd0;
	localparam logic [1:0] HDR_STATUS_HI = 2'd1;
	localparam logic [1:0] HDR_LEN_LO    = 2'd2;
	localparam logic [1:0] HDR_LEN_HI    = 2'd3;

	typedef enum logic [3:0] {
		PH_HDR       = 4'b0001,
		PH_PAY       = 4'b0010,
		PH_TAIL_ACC  = 4'b0100,
		PH_TAIL_SKIP = 4'b1000
	} rrd_phase_t;

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [7:0]  payload_byte;
		logic        record_accepted;
		logic [15:0] pointer_report;
		logic [31:0] good_count;
		logic [31:0] drop_count;
	} rrd_result_t;

endpackage

/* sv/rrd_skid.sv */
// Two-entry output stage: result register plus skid register.
// Depends on rrd_pkg for the result type.
module rrd_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rrd_pkg::rrd_result_t in_data,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rrd_pkg::rrd_result_t out_data
);
	import rrd_pkg::*;

	rrd_result_t out_q;
	rrd_result_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        out_free;

	// out slot can take a new entry this cycle
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_valid;
				end
			end else if (in_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

endmodule

/* sv/rx_ring_record_deframer_unit.sv */
// Receive-ring record deframer, top level. Uses rrd_pkg and rrd_skid.
// An accepted byte's result is registered into the rrd_skid output stage, where a stalled sink can hold it.
// Throughput: one ring byte per cycle while s_tready is high; the header/length parser updates on each accepted byte.
// s_tready drops only while both output entries are held by a stalled sink.
// Reset (arst_n, async): parser to header phase, pointer and counters to zero,
// max_frame_len to 1518, output stage empty.
module rx_ring_record_deframer_unit #(
	parameter int RING_BYTES = rrd_pkg::RING_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] ring_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rrd_pkg::TDATA_W-1:0] m_tdata,  // [7:0] payload_byte, [8] record_accepted,
	                                              // [24:9] pointer_report, [56:25] good_count,
	                                              // [88:57] drop_count, rest zero
	output logic                        m_tlast,  // payload_last
	output logic                        m_tuser,  // result_kind
	input  logic                        cfg_wr_en,
	input  logic [11:0]                 cfg_wr_data
);
	import rrd_pkg::*;

	localparam int PTR_W = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
	localparam int PAD_W = TDATA_W - 89;

	logic [11:0]      max_len_q;
	rrd_phase_t       phase_q, phase_nxt;
	logic [1:0]       hdr_idx_q, hdr_idx_nxt;
	logic             status_ok_q, status_ok_nxt;
	logic [15:0]      len_q, len_nxt;
	logic [16:0]      left_q, left_nxt;
	logic [PTR_W-1:0] ptr_q, ptr_nxt;
	logic [31:0]      good_cnt_q, good_cnt_nxt;
	logic [31:0]      drop_cnt_q, drop_cnt_nxt;

	logic        accept;
	logic        emit;
	logic        rd_ready;
	rrd_result_t res;
	rrd_result_t out_res;

	logic [15:0] hdr_len;
	logic [16:0] padded;
	logic [16:0] left_dec;
	logic [16:0] tail_len;
	logic        frame_ok;
	logic [15:0] ptr_report;

	assign s_tready = rd_ready;
	assign accept   = s_tvalid && rd_ready;

	always_comb begin
		ptr_nxt    = (ptr_q == PTR_W'(RING_BYTES - 1)) ? '0 : ptr_q + 1'b1;
		ptr_report = 16'(ptr_nxt) - PTR_REPORT_OFS;
		hdr_len    = {s_tdata, len_q[7:0]};
		padded     = (17'(hdr_len) + PAD_ROUND) & ~PAD_ROUND;
		frame_ok   = status_ok_q && (hdr_len >= MIN_FRAME_LEN) &&
		             (hdr_len <= 16'(max_len_q));
		left_dec   = (left_q != '0) ? left_q - 17'd1 : '0;
		// CRC plus padding after the last payload byte
		tail_len   = CRC_LEN + 17'(2'(2'd0 - len_q[1:0]));
	end

	always_comb begin
		phase_nxt     = phase_q;
		hdr_idx_nxt   = hdr_idx_q;
		status_ok_nxt = status_ok_q;
		len_nxt       = len_q;
		left_nxt      = left_q;
		good_cnt_nxt  = good_cnt_q;
		drop_cnt_nxt  = drop_cnt_q;
		emit          = 1'b0;
		res           = '0;

		unique case (phase_q)
			PH_HDR: begin
				unique case (hdr_idx_q)
					HDR_STATUS_LO: status_ok_nxt = (16'(s_tdata) & STATUS_OK_MASK) != '0;
					HDR_STATUS_HI: ;
					HDR_LEN_LO:    len_nxt = 16'(s_tdata);
					HDR_LEN_HI:    len_nxt = hdr_len;
					default:       ;
				endcase
				if (hdr_idx_q != HDR_LEN_HI) begin
					hdr_idx_nxt = hdr_idx_q + 2'd1;
				end else begin
					hdr_idx_nxt = HDR_STATUS_LO;
					if (frame_ok) begin
						good_cnt_nxt = good_cnt_q + 32'd1;
						left_nxt     = 17'(hdr_len) - CRC_LEN;
						phase_nxt    = PH_PAY;
					end else begin
						if (status_ok_q) drop_cnt_nxt = drop_cnt_q + 32'd1;
						if (padded == '0) begin
							// zero-length record ends on its last header byte
							emit                = 1'b1;
							res.kind            = KIND_END;
							res.pointer_report  = ptr_report;
							left_nxt            = '0;
						end else begin
							left_nxt  = padded;
							phase_nxt = PH_TAIL_SKIP;
						end
					end
				end
			end
			PH_PAY: begin
				emit             = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = s_tdata;
				if (left_dec == '0) begin
					res.last  = 1'b1;
					left_nxt  = tail_len;
					phase_nxt = PH_TAIL_ACC;
				end else begin
					left_nxt = left_dec;
				end
			end
			PH_TAIL_ACC, PH_TAIL_SKIP: begin
				left_nxt = left_dec;
				if (left_dec == '0) begin
					emit                = 1'b1;
					res.kind            = KIND_END;
					res.record_accepted = (phase_q == PH_TAIL_ACC);
					res.pointer_report  = ptr_report;
					phase_nxt           = PH_HDR;
					hdr_idx_nxt         = HDR_STATUS_LO;
				end
			end
			default: phase_nxt = PH_HDR;
		endcase

		res.good_count = good_cnt_nxt;
		res.drop_count = drop_cnt_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= MAX_LEN_RST;
			phase_q     <= PH_HDR;
			hdr_idx_q   <= HDR_STATUS_LO;
			status_ok_q <= 1'b0;
			len_q       <= '0;
			left_q      <= '0;
			ptr_q       <= '0;
			good_cnt_q  <= '0;
			drop_cnt_q  <= '0;
		end else begin
			if (cfg_wr_en) max_len_q <= cfg_wr_data;
			if (accept) begin
				phase_q     <= phase_nxt;
				hdr_idx_q   <= hdr_idx_nxt;
				status_ok_q <= status_ok_nxt;
				len_q       <= len_nxt;
				left_q      <= left_nxt;
				ptr_q       <= ptr_nxt;
				good_cnt_q  <= good_cnt_nxt;
				drop_cnt_q  <= drop_cnt_nxt;
			end
		end
	end

	rrd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && emit),
		.in_data   (res),
		.in_ready  (rd_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {{PAD_W{1'b0}}, out_res.drop_count, out_res.good_count,
	                  out_res.pointer_report, out_res.record_accepted, out_res.payload_byte};
	assign m_tlast = out_res.last;
	assign m_tuser = out_res.kind;

	// back-pressure only once the result register is occupied
	a_stall_implies_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output register");

	a_payload_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAY) |-> (left_q != '0))
		else $error("payload phase with no bytes left");

	a_hdr_idx_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_idx_q != HDR_STATUS_LO) |-> (phase_q == PH_HDR))
		else $error("header index running outside header phase");

	a_counts_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(good_cnt_q) && $stable(drop_cnt_q) && $stable(ptr_q)))
		else $error("parser state moved without an accepted byte");

endmodule

/* tb/rx_ring_record_deframer_unit_test.sv */
// Self-checking testbench for rx_ring_record_deframer_unit: builds ring records,
// predicts every payload byte and record-end report, checks m_* field by field.
// Depends on rrd_pkg and the RTL under sv/.
`timescale 1ns / 100ps

module rx_ring_record_deframer_unit_test;
	import rrd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 4;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                s_tvalid    = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata     = '0;
	logic                m_tvalid;
	logic                m_tready    = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;
	logic                m_tuser;
	logic                cfg_wr_en   = 1'b0;
	logic [11:0]         cfg_wr_data = '0;

	// parser shadow state
	rrd_phase_t          parse_state = PH_HDR;
	logic [1:0]          hdr_idx     = HDR_STATUS_LO;
	logic                stat_ok     = 1'b0;
	logic [15:0]         rec_len     = '0;
	logic [16:0]         body_left   = '0;
	int                  rd_ptr      = 0;
	logic [31:0]         good_tot    = '0;
	logic [31:0]         drop_tot    = '0;
	logic [11:0]         lim_len     = MAX_LEN_RST;

	rrd_result_t         deframer_results_q[$];
	int                  mismatches     = 0;
	int                  stall_run      = 0;
	int                  sent_bytes     = 0;
	int                  src_idle_pct   = 0;
	int                  sink_stall_pct = 0;
	bit                  long_hold_req  = 1'b0;

	rx_ring_record_deframer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [16:0] pad4(input logic [15:0] len);
		return ({1'b0, len} + PAD_ROUND) & ~PAD_ROUND;
	endfunction

	function automatic void close_record(output rrd_result_t r, input logic acc);
		parse_state      = PH_HDR;
		hdr_idx          = HDR_STATUS_LO;
		body_left        = '0;
		r                = '0;
		r.kind           = KIND_END;
		r.record_accepted = acc;
		r.pointer_report = 16'(rd_ptr) - PTR_REPORT_OFS;
		r.good_count     = good_tot;
		r.drop_count     = drop_tot;
	endfunction

	// Advances the shadow parser by one ring byte; returns 1 if a result is due.
	function automatic bit deframe_byte(input logic [7:0] b, output rrd_result_t r);
		r = '0;
		rd_ptr = (rd_ptr + 1) % RING_BYTES_DEF;
		case (parse_state)
			PH_HDR: begin
				case (hdr_idx)
					HDR_STATUS_LO: stat_ok = b[0];
					HDR_LEN_LO:    rec_len = {8'h00, b};
					HDR_LEN_HI:    rec_len[15:8] = b;
					default: ;  // status high byte carries nothing
				endcase
				if (hdr_idx != HDR_LEN_HI) begin
					hdr_idx++;
					return 1'b0;
				end
				hdr_idx = HDR_STATUS_LO;
				if (stat_ok && rec_len >= MIN_FRAME_LEN && rec_len <= {4'h0, lim_len}) begin
					good_tot++;
					body_left   = {1'b0, rec_len} - CRC_LEN;
					parse_state = PH_PAY;
					return 1'b0;
				end
				if (stat_ok)
					drop_tot++;
				if (pad4(rec_len) == '0) begin
					close_record(r, 1'b0);
					return 1'b1;
				end
				body_left   = pad4(rec_len);
				parse_state = PH_TAIL_SKIP;
				return 1'b0;
			end
			PH_PAY: begin
				if (body_left != '0)
					body_left--;
				r.kind         = KIND_PAYLOAD;
				r.payload_byte = b;
				r.good_count   = good_tot;
				r.drop_count   = drop_tot;
				if (body_left == '0) begin
					r.last      = 1'b1;
					body_left   = pad4(rec_len) - {1'b0, rec_len} + CRC_LEN;
					parse_state = PH_TAIL_ACC;
				end
				return 1'b1;
			end
			default: begin
				// CRC plus padding, or a whole skipped body
				if (body_left != '0)
					body_left--;
				if (body_left == '0) begin
					close_record(r, parse_state == PH_TAIL_ACC);
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// request monitor, result checker and watchdog
	always @(posedge clk) begin
		rrd_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (deframe_byte(s_tdata, want))
					deframer_results_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (deframer_results_q.size() == 0) begin
					$error("unexpected result: kind %0b, data %0h", m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = deframer_results_q.pop_front();
					check_field("result_kind", want.kind, m_tuser);
					check_field("payload_last", want.last, m_tlast);
					check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
					check_field("record_accepted", want.record_accepted, m_tdata[8]);
					check_field("pointer_report", want.pointer_report, m_tdata[24:9]);
					check_field("good_count", want.good_count, m_tdata[56:25]);
					check_field("drop_count", want.drop_count, m_tdata[88:57]);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_run = 0;
			else
				stall_run++;
			if (stall_run >= WATCHDOG_LIMIT) begin
				$display("rx_ring_record_deframer_unit regression: fail");
				$finish;
			end
		end
	end

	// sink: random stalls, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// each cycle the sender sits idle with probability src_idle_pct
	task automatic send_byte(input logic [7:0] b);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
	endtask

	task automatic send_header(input bit ok, input logic [15:0] len);
		send_byte({7'($urandom), ok});
		send_byte(8'($urandom));
		send_byte(len[7:0]);
		send_byte(len[15:8]);
	endtask

	// body covers payload, CRC and padding alike; fill < 0 means random bytes
	task automatic send_body(input logic [15:0] len, input int fill);
		int n;
		n = int'(pad4(len));
		for (int i = 0; i < n; i++)
			send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
	endtask

	task automatic send_record(input bit ok, input logic [15:0] len, input int fill = -1);
		send_header(ok, len);
		send_body(len, fill);
	endtask

	// let the monitor log the last accepted request before the queue is checked
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (deframer_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [11:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		lim_len = v;
	endtask

	task automatic test_short_records();
		send_record(1'b1, 16'd0);
		send_record(1'b0, 16'd0);
		send_record(1'b1, 16'd1);
		send_record(1'b0, 16'd3);
		send_record(1'b1, 16'd4);
		send_record(1'b1, 16'd13);
		send_record(1'b1, 16'd14, 8'h00);
		send_record(1'b1, 16'd14, 8'hFF);
		send_record(1'b0, 16'd15);
	endtask

	task automatic test_limit_edges();
		write_max_len(12'd20);
		send_record(1'b1, 16'd20);
		send_record(1'b1, 16'd21);
		send_record(1'b0, 16'd21);
		write_max_len(12'hFFF);
		send_record(1'b1, 16'd4095);
		send_record(1'b1, 16'd4096);
	endtask

	task automatic test_small_limit();
		write_max_len(12'd13);
		send_record(1'b1, 16'd14);
		send_record(1'b1, 16'd13);
		write_max_len(12'd0);
		send_record(1'b1, 16'd14);
		send_record(1'b0, 16'd14);
	endtask

	// new limit lands after the header, so only the next record sees it
	task automatic test_limit_mid_record();
		write_max_len(MAX_LEN_RST);
		send_header(1'b1, 16'd24);
		write_max_len(12'd14);
		send_body(16'd24, -1);
		send_record(1'b1, 16'd24);
	endtask

	task automatic test_huge_record();
		send_record(1'b1, 16'hFFFF);
		send_record(1'b1, 16'd14);
	endtask

	task automatic test_output_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_max_len(MAX_LEN_RST);
		long_hold_req = 1'b1;
		repeat (3) send_record(1'b1, 16'd20);
		drain_results();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [11:0] lim, input int budget);
		int start;
		int sel;
		int top;
		logic [15:0] len;
		write_max_len(lim);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		start = sent_bytes;
		while (sent_bytes - start < budget) begin
			sel = $urandom_range(99);
			top = (lim < 80) ? int'(lim) : 80;
			if (sel < 70 && top >= 14) begin
				send_record(1'b1, 16'($urandom_range(14, top)));
			end else if (sel < 80) begin
				send_record(1'b1, 16'($urandom_range(0, 13)));
			end else if (sel < 88 && lim < 100) begin
				send_record(1'b1, 16'(lim) + 16'($urandom_range(1, 8)));
			end else if (sel < 95) begin
				send_record(1'b0, 16'($urandom_range(0, 40)));
			end else begin
				// noise: arbitrary status, length kept short enough to stay cheap
				len = {6'd0, 10'($urandom)};
				send_record(1'($urandom), len);
			end
			// sender pause until everything outstanding has come back
			if (sel == 50)
				drain_results();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_records();
		test_limit_edges();
		test_small_limit();
		test_limit_mid_record();
		test_huge_record();
		test_output_backpressure();
		test_random_traffic(0, 0, 12'd40, 250);
		test_random_traffic(49, 0, 12'hFFF, 250);
		test_random_traffic(0, 49, 12'd14, 250);
		test_random_traffic(35, 35, 12'd60, 250);
		drain_results();
		if (mismatches == 0)
			$display("rx_ring_record_deframer_unit regression: pass");
		else
			$display("rx_ring_record_deframer_unit regression: fail");
		$finish;
	end

endmodule
